// ===== hw/rtl/atapio_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO read sequencer package
// Shared codes, constants and the result record.
// ----------------------------------------------------------------------------
package atapio_pkg;

  localparam int unsigned WORDS_PER_SECTOR = 256;
  localparam logic [23:0] POLL_LIMIT_RESET = 24'd2000000;

  localparam logic [1:0] OP_START  = 2'd0;
  localparam logic [1:0] OP_STATUS = 2'd1;
  localparam logic [1:0] OP_DATA   = 2'd2;

  localparam logic [1:0] ACT_NONE  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_READ  = 2'd2;

  localparam logic [2:0] REG_DATA    = 3'd0;
  localparam logic [2:0] REG_COUNT   = 3'd2;
  localparam logic [2:0] REG_LBA_LO  = 3'd3;
  localparam logic [2:0] REG_LBA_MID = 3'd4;
  localparam logic [2:0] REG_LBA_HI  = 3'd5;
  localparam logic [2:0] REG_DRIVE   = 3'd6;
  localparam logic [2:0] REG_STATUS  = 3'd7;

  localparam logic [7:0] DRIVE_LBA = 8'hE0;
  localparam logic [7:0] CMD_READ  = 8'h20;

  localparam int unsigned ST_BSY = 7;
  localparam int unsigned ST_DRQ = 3;
  localparam int unsigned ST_ERR = 0;

  typedef struct packed {
    logic        failed;
    logic        finished;
    logic [15:0] word_offset;
    logic [15:0] word_value;
    logic        word_valid;
    logic [7:0]  write_value;
    logic [2:0]  register;
    logic [1:0]  action;
  } result_t;

  typedef struct packed {
    logic    load;
    logic    burst;
    logic    zero_count;
    result_t res;
  } req_t;

endpackage

// ===== hw/rtl/ata_pio_sector_read_sequencer.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sector read sequencer
// Host-side sequencer: status polls, command burst, sector data reads.
// ----------------------------------------------------------------------------
// The first result of an item appears in the cycle after it is accepted.
// Throughput: one item per cycle for items with one result, while the output
//   is not stalled; the command burst holds the result register for seven results.
// Reset: idle, all counters zero, busy poll limit 2000000.
module ata_pio_sector_read_sequencer #(
  parameter int unsigned WORDS_PER_SECTOR = atapio_pkg::WORDS_PER_SECTOR
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [23:0] cfg_data_i,     // bsy_poll_limit
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,   // lba, sector_count, read_value, pad
  input  logic [1:0]  s_axis_tuser,   // opcode
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [47:0] m_axis_tdata,   // register, write_value, word_valid,
                                      // word_value, word_offset, finished,
                                      // failed, pad
  output logic [1:0]  m_axis_tuser,   // bus_action
  output logic        m_axis_tlast
);

  localparam int unsigned WW = $clog2(WORDS_PER_SECTOR);
  localparam logic [WW-1:0] WORD_LAST = WW'(WORDS_PER_SECTOR - 1);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_BSY_CMD,
    PH_BSY_SEC,
    PH_DRQ,
    PH_DATA
  } phase_e;

  phase_e         phase_q, phase_d;
  logic [27:0]    addr_q, addr_d;
  logic [7:0]     total_q, total_d;
  logic [7:0]     sector_q, sector_d;
  logic [WW-1:0]  word_q, word_d;
  logic [23:0]    poll_q, poll_d;
  logic [15:0]    offset_q, offset_d;
  logic [23:0]    limit_q, limit_d;

  atapio_pkg::req_t req;
  logic             free;
  logic             accept;
  logic [1:0]       op;
  logic [7:0]       st;
  logic [15:0]      val;
  logic [24:0]      poll_next;
  logic [7:0]       sector_next;

  assign s_axis_tready = free;
  assign cfg_ready_o   = 1'b1;
  assign accept        = s_axis_tvalid && free;
  assign op            = s_axis_tuser;
  assign val           = s_axis_tdata[51:36];
  assign st            = val[7:0];
  assign poll_next     = {1'b0, poll_q} + 25'd1;
  assign sector_next   = sector_q + 8'd1;

  always_comb begin
    phase_d  = phase_q;
    addr_d   = addr_q;
    total_d  = total_q;
    sector_d = sector_q;
    word_d   = word_q;
    poll_d   = poll_q;
    offset_d = offset_q;
    limit_d  = cfg_valid_i ? cfg_data_i : limit_q;
    req      = '0;

    if (accept) begin
      if (op == atapio_pkg::OP_START) begin
        addr_d           = s_axis_tdata[27:0];
        total_d          = s_axis_tdata[35:28];
        sector_d         = 8'd0;
        word_d           = '0;
        poll_d           = 24'd0;
        offset_d         = 16'd0;
        phase_d          = PH_BSY_CMD;
        req.load         = 1'b1;
        req.res.action   = atapio_pkg::ACT_READ;
        req.res.register = atapio_pkg::REG_STATUS;
      end else if (op == atapio_pkg::OP_STATUS &&
                   (phase_q == PH_BSY_CMD || phase_q == PH_BSY_SEC) &&
                   st[atapio_pkg::ST_BSY]) begin
        req.load = 1'b1;
        if (poll_next >= {1'b0, limit_q}) begin
          phase_d        = PH_IDLE;
          req.res.failed = 1'b1;
        end else begin
          poll_d           = poll_next[23:0];
          req.res.action   = atapio_pkg::ACT_READ;
          req.res.register = atapio_pkg::REG_STATUS;
        end
      end else if (op == atapio_pkg::OP_STATUS && phase_q == PH_BSY_CMD) begin
        req.load       = 1'b1;
        req.burst      = 1'b1;
        req.zero_count = (total_q == 8'd0);
        phase_d        = (total_q == 8'd0) ? PH_IDLE : PH_BSY_SEC;
        poll_d         = 24'd0;
        sector_d       = 8'd0;
      end else if (op == atapio_pkg::OP_STATUS && phase_q == PH_BSY_SEC) begin
        phase_d          = PH_DRQ;
        req.load         = 1'b1;
        req.res.action   = atapio_pkg::ACT_READ;
        req.res.register = atapio_pkg::REG_STATUS;
      end else if (op == atapio_pkg::OP_STATUS && phase_q == PH_DRQ) begin
        req.load = 1'b1;
        if (st[atapio_pkg::ST_ERR]) begin
          phase_d        = PH_IDLE;
          req.res.failed = 1'b1;
        end else if (st[atapio_pkg::ST_DRQ]) begin
          phase_d          = PH_DATA;
          word_d           = '0;
          req.res.action   = atapio_pkg::ACT_READ;
          req.res.register = atapio_pkg::REG_DATA;
        end else begin
          req.res.action   = atapio_pkg::ACT_READ;
          req.res.register = atapio_pkg::REG_STATUS;
        end
      end else if (op == atapio_pkg::OP_DATA && phase_q == PH_DATA) begin
        req.load               = 1'b1;
        req.res.word_valid     = 1'b1;
        req.res.word_value     = val;
        req.res.word_offset    = offset_q;
        offset_d               = offset_q + 16'd1;
        if (word_q == WORD_LAST) begin
          word_d   = '0;
          sector_d = sector_next;
          if (sector_next >= total_q) begin
            phase_d          = PH_IDLE;
            req.res.finished = 1'b1;
          end else begin
            phase_d          = PH_BSY_SEC;
            poll_d           = 24'd0;
            req.res.action   = atapio_pkg::ACT_READ;
            req.res.register = atapio_pkg::REG_STATUS;
          end
        end else begin
          word_d           = word_q + WW'(1);
          req.res.action   = atapio_pkg::ACT_READ;
          req.res.register = atapio_pkg::REG_DATA;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q  <= PH_IDLE;
      addr_q   <= 28'd0;
      total_q  <= 8'd0;
      sector_q <= 8'd0;
      word_q   <= '0;
      poll_q   <= 24'd0;
      offset_q <= 16'd0;
      limit_q  <= atapio_pkg::POLL_LIMIT_RESET;
    end else begin
      phase_q  <= phase_d;
      addr_q   <= addr_d;
      total_q  <= total_d;
      sector_q <= sector_d;
      word_q   <= word_d;
      poll_q   <= poll_d;
      offset_q <= offset_d;
      limit_q  <= limit_d;
    end
  end

  atapio_out u_out (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .req_i         (req),
    .addr_i        (addr_q),
    .count_i       (total_q),
    .free_o        (free),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

endmodule

// ===== hw/rtl/atapio_out.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO read sequencer output stage
// Result register; expands the command burst into seven items.
// ----------------------------------------------------------------------------
module atapio_out (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  atapio_pkg::req_t   req_i,
  input  logic [27:0]        addr_i,
  input  logic [7:0]         count_i,
  output logic               free_o,
  output logic               m_axis_tvalid,
  input  logic               m_axis_tready,
  output logic [47:0]        m_axis_tdata,  // register, write_value, word_valid,
                                            // word_value, word_offset, finished,
                                            // failed, pad
  output logic [1:0]         m_axis_tuser,  // bus_action
  output logic               m_axis_tlast
);

  localparam logic [2:0] BURST_LAST = 3'd6;

  function automatic atapio_pkg::result_t burst_result(
    input logic [2:0]  idx,
    input logic [27:0] addr,
    input logic [7:0]  count,
    input logic        zero
  );
    atapio_pkg::result_t r;
    r = '0;
    r.action = atapio_pkg::ACT_WRITE;
    case (idx)
      3'd0: begin
        r.register    = atapio_pkg::REG_DRIVE;
        r.write_value = atapio_pkg::DRIVE_LBA | {4'h0, addr[27:24]};
      end
      3'd1: begin
        r.register    = atapio_pkg::REG_COUNT;
        r.write_value = count;
      end
      3'd2: begin
        r.register    = atapio_pkg::REG_LBA_LO;
        r.write_value = addr[7:0];
      end
      3'd3: begin
        r.register    = atapio_pkg::REG_LBA_MID;
        r.write_value = addr[15:8];
      end
      3'd4: begin
        r.register    = atapio_pkg::REG_LBA_HI;
        r.write_value = addr[23:16];
      end
      3'd5: begin
        r.register    = atapio_pkg::REG_STATUS;
        r.write_value = atapio_pkg::CMD_READ;
      end
      default: begin
        if (zero) begin
          r.action   = atapio_pkg::ACT_NONE;
          r.finished = 1'b1;
        end else begin
          r.action   = atapio_pkg::ACT_READ;
          r.register = atapio_pkg::REG_STATUS;
        end
      end
    endcase
    return r;
  endfunction

  logic                valid_q, valid_d;
  logic                burst_q, burst_d;
  logic [2:0]          idx_q, idx_d;
  logic                zero_q, zero_d;
  atapio_pkg::result_t res_q, res_d;
  logic                last;

  assign last   = !burst_q || (idx_q == BURST_LAST);
  assign free_o = !valid_q || (m_axis_tready && last);

  always_comb begin
    valid_d = valid_q;
    burst_d = burst_q;
    idx_d   = idx_q;
    zero_d  = zero_q;
    res_d   = res_q;
    if (req_i.load) begin
      valid_d = 1'b1;
      burst_d = req_i.burst;
      idx_d   = 3'd0;
      zero_d  = req_i.zero_count;
      res_d   = req_i.burst ? burst_result(3'd0, addr_i, count_i, req_i.zero_count)
                            : req_i.res;
    end else if (valid_q && m_axis_tready) begin
      if (!last) begin
        idx_d = idx_q + 3'd1;
        res_d = burst_result(idx_q + 3'd1, addr_i, count_i, zero_q);
      end else begin
        valid_d = 1'b0;
        burst_d = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      burst_q <= 1'b0;
      idx_q   <= 3'd0;
    end else begin
      valid_q <= valid_d;
      burst_q <= burst_d;
      idx_q   <= idx_d;
    end
  end

  always_ff @(posedge clk_i) begin
    zero_q <= zero_d;
    res_q  <= res_d;
  end

  assign m_axis_tvalid = valid_q;
  assign m_axis_tlast  = last;
  assign m_axis_tuser  = res_q.action;
  assign m_axis_tdata  = {2'b00, res_q.failed, res_q.finished, res_q.word_offset,
                          res_q.word_value, res_q.word_valid, res_q.write_value,
                          res_q.register};

endmodule

// ===== dv/ata_pio_sector_read_sequencer_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ATA PIO LBA28 sector read sequencer testbench
// Plays the drive side of a PIO read: a host item stream of start requests,
// status bytes and data words is produced by a drive emulation that follows
// the sequencer phase, with noise, aborted reads and restarts mixed in. Each
// accepted item runs through a bit-accurate predictor of the sequencer, and
// every bus request, delivered word and completion flag leaving the block is
// checked against the predicted list in order. Short sectors keep full reads
// within a few hundred items; the busy poll limit is swept between phases.
// ----------------------------------------------------------------------------
module ata_pio_sector_read_sequencer_test;

  localparam int unsigned WORDS = 64;
  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned HOLD_CYCLES = 200;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef enum logic [2:0] {
    SEQ_IDLE, SEQ_BSY_CMD, SEQ_BSY_SEC, SEQ_DRQ, SEQ_DATA
  } seq_phase_e;

  typedef struct packed {
    logic [23:0] poll_limit;
    seq_phase_e  phase;
    logic [27:0] lba;
    logic [7:0]  total;
    logic [7:0]  sector;
    logic [15:0] word;
    logic [23:0] polls;
  } seq_state_t;

  typedef struct packed {
    logic                last;
    atapio_pkg::result_t res;
  } bus_step_t;

  typedef bus_step_t step_list_t[$];

  typedef struct packed {
    logic [1:0]  op;
    logic [27:0] lba;
    logic [7:0]  cnt;
    logic [15:0] val;
  } host_item_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [23:0] cfg_data_i = '0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;   // lba, sector_count, read_value, pad
  logic [1:0]  s_axis_tuser = '0;   // opcode
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [47:0] m_axis_tdata;        // register, write_value, word_valid,
                                    // word_value, word_offset, finished,
                                    // failed, pad
  logic [1:0]  m_axis_tuser;        // bus_action
  logic        m_axis_tlast;

  ata_pio_sector_read_sequencer #(
    .WORDS_PER_SECTOR(WORDS)
  ) uut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  host_item_t  pending_items[$];
  bus_step_t   steps_due[$];
  seq_state_t  gen_seq;
  seq_state_t  dut_seq;
  int unsigned counted = 0;
  int unsigned errors = 0;
  int unsigned idle_cycles = 0;
  logic        in_fire = 1'b0;
  logic        cfg_fire = 1'b0;
  logic        calm = 1'b0;
  logic        hold_go = 1'b0;
  logic        hold_done = 1'b0;
  int unsigned hold_left = 0;
  int unsigned src_gap = 0;
  int unsigned snk_gap = 0;

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  function automatic atapio_pkg::result_t pack_result(logic [1:0] act, logic [2:0] rg,
                                                      logic [7:0] wv, logic wvalid,
                                                      logic [15:0] word,
                                                      logic [15:0] off,
                                                      logic fin, logic fail);
    atapio_pkg::result_t r;
    r.action      = act;
    r.register    = rg;
    r.write_value = wv;
    r.word_valid  = wvalid;
    r.word_value  = word;
    r.word_offset = off;
    r.finished    = fin;
    r.failed      = fail;
    return r;
  endfunction

  function automatic atapio_pkg::result_t bus_read(logic [2:0] rg, logic wvalid,
                                                   logic [15:0] word, logic [15:0] off);
    return pack_result(atapio_pkg::ACT_READ, rg, 8'h00, wvalid, word, off, 1'b0, 1'b0);
  endfunction

  function automatic atapio_pkg::result_t bus_write(logic [2:0] rg, logic [7:0] wv);
    return pack_result(atapio_pkg::ACT_WRITE, rg, wv, 1'b0, '0, '0, 1'b0, 1'b0);
  endfunction

  function automatic atapio_pkg::result_t bus_done(logic fin, logic fail);
    return pack_result(atapio_pkg::ACT_NONE, 3'd0, 8'h00, 1'b0, '0, '0, fin, fail);
  endfunction

  function automatic seq_state_t idle_state(logic [23:0] limit);
    seq_state_t s;
    s = '0;
    s.poll_limit = limit;
    s.phase = SEQ_IDLE;
    return s;
  endfunction

  function automatic void advance_read(inout seq_state_t s, input logic [1:0] op,
                                       input logic [27:0] lba, input logic [7:0] cnt,
                                       input logic [15:0] val, output step_list_t steps);
    atapio_pkg::result_t rs[$];
    logic [7:0]  st;
    logic [23:0] polls_next;
    logic [15:0] off;
    bus_step_t   b;
    st = val[7:0];
    steps = {};
    if (op == atapio_pkg::OP_START) begin
      s.lba = lba;
      s.total = cnt;
      s.sector = '0;
      s.word = '0;
      s.polls = '0;
      s.phase = SEQ_BSY_CMD;
      rs.push_back(bus_read(atapio_pkg::REG_STATUS, 1'b0, '0, '0));
    end else if (op == atapio_pkg::OP_STATUS &&
                 (s.phase == SEQ_BSY_CMD || s.phase == SEQ_BSY_SEC) &&
                 st[atapio_pkg::ST_BSY]) begin
      polls_next = s.polls + 24'd1;
      if (polls_next >= s.poll_limit) begin
        s.phase = SEQ_IDLE;
        rs.push_back(bus_done(1'b0, 1'b1));
      end else begin
        s.polls = polls_next;
        rs.push_back(bus_read(atapio_pkg::REG_STATUS, 1'b0, '0, '0));
      end
    end else if (op == atapio_pkg::OP_STATUS && s.phase == SEQ_BSY_CMD) begin
      rs.push_back(bus_write(atapio_pkg::REG_DRIVE,
                             atapio_pkg::DRIVE_LBA | {4'h0, s.lba[27:24]}));
      rs.push_back(bus_write(atapio_pkg::REG_COUNT, s.total));
      rs.push_back(bus_write(atapio_pkg::REG_LBA_LO, s.lba[7:0]));
      rs.push_back(bus_write(atapio_pkg::REG_LBA_MID, s.lba[15:8]));
      rs.push_back(bus_write(atapio_pkg::REG_LBA_HI, s.lba[23:16]));
      rs.push_back(bus_write(atapio_pkg::REG_STATUS, atapio_pkg::CMD_READ));
      if (s.total == 8'd0) begin
        s.phase = SEQ_IDLE;
        rs.push_back(bus_done(1'b1, 1'b0));
      end else begin
        s.phase = SEQ_BSY_SEC;
        s.polls = '0;
        s.sector = '0;
        rs.push_back(bus_read(atapio_pkg::REG_STATUS, 1'b0, '0, '0));
      end
    end else if (op == atapio_pkg::OP_STATUS && s.phase == SEQ_BSY_SEC) begin
      s.phase = SEQ_DRQ;
      rs.push_back(bus_read(atapio_pkg::REG_STATUS, 1'b0, '0, '0));
    end else if (op == atapio_pkg::OP_STATUS && s.phase == SEQ_DRQ) begin
      if (st[atapio_pkg::ST_ERR]) begin
        s.phase = SEQ_IDLE;
        rs.push_back(bus_done(1'b0, 1'b1));
      end else if (st[atapio_pkg::ST_DRQ]) begin
        s.phase = SEQ_DATA;
        s.word = '0;
        rs.push_back(bus_read(atapio_pkg::REG_DATA, 1'b0, '0, '0));
      end else begin
        rs.push_back(bus_read(atapio_pkg::REG_STATUS, 1'b0, '0, '0));
      end
    end else if (op == atapio_pkg::OP_DATA && s.phase == SEQ_DATA) begin
      off = 16'(32'(s.sector) * WORDS + 32'(s.word));
      s.word = s.word + 16'd1;
      if (32'(s.word) >= WORDS) begin
        s.word = '0;
        s.sector = s.sector + 8'd1;
        if (s.sector >= s.total) begin
          s.phase = SEQ_IDLE;
          rs.push_back(pack_result(atapio_pkg::ACT_NONE, 3'd0, 8'h00, 1'b1, val, off,
                                   1'b1, 1'b0));
        end else begin
          s.phase = SEQ_BSY_SEC;
          s.polls = '0;
          rs.push_back(bus_read(atapio_pkg::REG_STATUS, 1'b1, val, off));
        end
      end else begin
        rs.push_back(bus_read(atapio_pkg::REG_DATA, 1'b1, val, off));
      end
    end
    foreach (rs[i]) begin
      b.res = rs[i];
      b.last = (i == rs.size() - 1);
      steps.push_back(b);
    end
  endfunction

  // drive side emulation: queue an item and track where the sequencer will be
  task automatic offer(input logic [1:0] op, input logic [27:0] lba,
                       input logic [7:0] cnt, input logic [15:0] val);
    host_item_t it;
    step_list_t steps;
    it.op = op;
    it.lba = lba;
    it.cnt = cnt;
    it.val = val;
    pending_items.push_back(it);
    advance_read(gen_seq, op, lba, cnt, val, steps);
    if (steps.size() > 0) counted++;
  endtask

  task automatic respond(input logic [1:0] op, input logic [15:0] val);
    offer(op, 28'($urandom), 8'($urandom), val);
  endtask

  task automatic play_read(input logic [27:0] lba, input logic [7:0] cnt,
                           input int noise_pct, input int bsy_pct,
                           input int max_answers);
    int         n;
    int         pick;
    logic [15:0] v;
    offer(atapio_pkg::OP_START, lba, cnt, 16'($urandom));
    n = 0;
    while (gen_seq.phase != SEQ_IDLE && n < max_answers) begin
      n++;
      v = 16'($urandom);
      if ($urandom_range(0, 99) < noise_pct) begin
        offer(2'($urandom), 28'($urandom), 8'($urandom_range(0, 2)), v);
      end else begin
        case (gen_seq.phase)
          SEQ_BSY_CMD, SEQ_BSY_SEC: begin
            v[atapio_pkg::ST_BSY] = ($urandom_range(0, 99) < bsy_pct);
            respond(atapio_pkg::OP_STATUS, v);
          end
          SEQ_DRQ: begin
            pick = $urandom_range(0, 99);
            if (pick < 4) begin
              v[atapio_pkg::ST_ERR] = 1'b1;
            end else begin
              v[atapio_pkg::ST_ERR] = 1'b0;
              v[atapio_pkg::ST_DRQ] = (pick < 45);
            end
            respond(atapio_pkg::OP_STATUS, v);
          end
          default: respond(atapio_pkg::OP_DATA, v);
        endcase
      end
    end
  endtask

  task automatic random_phase(input int unsigned budget, input int bsy_pct);
    int unsigned goal;
    int          pick;
    int          room;
    logic [7:0]  cnt;
    goal = counted + budget;
    while (counted < goal) begin
      room = int'(goal - counted);
      pick = $urandom_range(0, 9);
      if (pick < 5) begin
        pick = $urandom_range(0, 9);
        cnt = (pick < 3) ? 8'd0 : (pick < 9) ? 8'd1 : 8'd2;
        play_read(28'($urandom), cnt, 0, bsy_pct, room);
      end else if (pick < 8) begin
        play_read(28'($urandom), 8'($urandom_range(0, 2)), 10, bsy_pct, room);
      end else begin
        // abandoned by the next start
        play_read(28'($urandom), 8'($urandom), 0, bsy_pct, $urandom_range(0, 6));
      end
    end
  endtask

  task automatic settle();
    while (pending_items.size() != 0 || s_axis_tvalid || steps_due.size() != 0)
      @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_limit(input logic [23:0] value);
    settle();
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_data_i <= value;
    gen_seq.poll_limit = value;
    do @(negedge clk_i); while (!cfg_fire);
    cfg_valid_i <= 1'b0;
  endtask

  // host item driver
  always @(negedge clk_i) begin
    host_item_t it;
    if (!s_axis_tvalid || in_fire) begin
      if (src_gap > 0) begin
        s_axis_tvalid <= 1'b0;
        src_gap <= src_gap - 1;
      end else if (pending_items.size() > 0 && rst_ni) begin
        if (!calm && $urandom_range(0, 9) == 0) begin
          s_axis_tvalid <= 1'b0;
          src_gap <= $urandom_range(0, 11);
        end else begin
          it = pending_items.pop_front();
          s_axis_tdata <= {4'h0, it.val, it.cnt, it.lba};
          s_axis_tuser <= it.op;
          s_axis_tvalid <= 1'b1;
        end
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  // result sink
  always @(negedge clk_i) begin
    if (hold_left > 0) begin
      m_axis_tready <= 1'b0;
      hold_left <= hold_left - 1;
    end else if (hold_go && !hold_done) begin
      m_axis_tready <= 1'b0;
      hold_left <= HOLD_CYCLES - 1;
      hold_done <= 1'b1;
    end else if (snk_gap > 0) begin
      m_axis_tready <= 1'b0;
      snk_gap <= snk_gap - 1;
    end else if (!calm && $urandom_range(0, 7) == 0) begin
      m_axis_tready <= 1'b0;
      snk_gap <= $urandom_range(0, 11);
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // monitor and checker
  always @(posedge clk_i) begin
    step_list_t          steps;
    bus_step_t           want;
    atapio_pkg::result_t got;
    logic                s_hit;
    logic                m_hit;
    logic                c_hit;
    s_hit = s_axis_tvalid && s_axis_tready;
    m_hit = m_axis_tvalid && m_axis_tready;
    c_hit = cfg_valid_i && cfg_ready_o;
    in_fire <= s_hit;
    cfg_fire <= c_hit;
    idle_cycles <= (s_hit || m_hit || c_hit) ? 0 : idle_cycles + 1;
    if (c_hit) dut_seq.poll_limit = cfg_data_i;
    if (s_hit) begin
      advance_read(dut_seq, s_axis_tuser, s_axis_tdata[27:0], s_axis_tdata[35:28],
                   s_axis_tdata[51:36], steps);
      foreach (steps[i]) steps_due.push_back(steps[i]);
    end
    if (m_hit) begin
      got.action      = m_axis_tuser;
      got.register    = m_axis_tdata[2:0];
      got.write_value = m_axis_tdata[10:3];
      got.word_valid  = m_axis_tdata[11];
      got.word_value  = m_axis_tdata[27:12];
      got.word_offset = m_axis_tdata[43:28];
      got.finished    = m_axis_tdata[44];
      got.failed      = m_axis_tdata[45];
      if (steps_due.size() == 0) begin
        if (errors < 10)
          $display("unexpected result: act=%0d reg=%0d wv=%h word=%b/%h off=%h fin=%b fail=%b",
                   got.action, got.register, got.write_value, got.word_valid,
                   got.word_value, got.word_offset, got.finished, got.failed);
        errors++;
      end else begin
        want = steps_due.pop_front();
        if (got !== want.res || m_axis_tlast !== want.last) begin
          if (errors < 10) begin
            $display("mismatch want: act=%0d reg=%0d wv=%h word=%b/%h off=%h fin=%b fail=%b last=%b",
                     want.res.action, want.res.register, want.res.write_value,
                     want.res.word_valid, want.res.word_value, want.res.word_offset,
                     want.res.finished, want.res.failed, want.last);
            $display("         got:  act=%0d reg=%0d wv=%h word=%b/%h off=%h fin=%b fail=%b last=%b",
                     got.action, got.register, got.write_value, got.word_valid,
                     got.word_value, got.word_offset, got.finished, got.failed,
                     m_axis_tlast);
          end
          errors++;
        end
      end
    end
  end

  initial begin : watchdog
    while (idle_cycles < WATCHDOG_LIMIT) @(posedge clk_i);
    $display("ata_pio_sector_read_sequencer verification failed");
    $finish;
  end

  initial begin
    gen_seq = idle_state(atapio_pkg::POLL_LIMIT_RESET);
    dut_seq = idle_state(atapio_pkg::POLL_LIMIT_RESET);
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // zero count at the top address, finished right after the command
    offer(atapio_pkg::OP_START, 28'hFFFFFFF, 8'd0, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'hFF00);
    // busy polls, full count, DRQ wait, data extremes, stray answers
    offer(atapio_pkg::OP_START, 28'h0000000, 8'd255, 16'hFFFF);
    respond(atapio_pkg::OP_STATUS, 16'h0080);
    respond(atapio_pkg::OP_STATUS, 16'h00FF);
    respond(atapio_pkg::OP_STATUS, 16'hFF7F);
    respond(atapio_pkg::OP_STATUS, 16'h0080);
    respond(atapio_pkg::OP_DATA, 16'h1234);
    respond(atapio_pkg::OP_STATUS, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0008);
    respond(atapio_pkg::OP_DATA, 16'hFFFF);
    respond(atapio_pkg::OP_DATA, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0080);
    respond(2'd3, 16'hFFFF);
    // restart in the data phase, then an error status
    offer(atapio_pkg::OP_START, 28'hA5A5A5A, 8'd1, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0009);
    respond(atapio_pkg::OP_DATA, 16'hBEEF);

    // one poll allowed: busy fails at once, in both poll phases
    write_limit(24'd1);
    offer(atapio_pkg::OP_START, 28'h5A5A5A5, 8'd1, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0080);
    offer(atapio_pkg::OP_START, 28'h0123456, 8'd1, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0000);
    respond(atapio_pkg::OP_STATUS, 16'h0080);
    random_phase(55, 10);

    write_limit(24'hFFFFFF);
    random_phase(60, 30);
    @(posedge clk_i);
    hold_go = 1'b1;

    write_limit(24'($urandom_range(2, 5)));
    random_phase(60, 40);

    write_limit(24'($urandom_range(1, 4)));
    @(posedge clk_i);
    calm = 1'b1;
    random_phase(55, 25);

    settle();
    if (errors == 0 && steps_due.size() == 0) begin
      $display("ata_pio_sector_read_sequencer verification clean");
    end else begin
      $display("ata_pio_sector_read_sequencer verification failed");
    end
    $finish;
  end

endmodule
